// File: rtl/iee_pkg.sv
// Shared types and constants for the infix expression evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iee_pkg;
  localparam int STACK_DEPTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIVZERO   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TK_DIGIT = 2'd0,
    TK_OPER  = 2'd1,
    TK_CLOSE = 2'd2,
    TK_NONE  = 2'd3
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } token_t;

  localparam int TOKEN_W = $bits(token_t);

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIGIT,
    S_PEEK,
    S_RED_B,
    S_RED_A,
    S_ALU,
    S_DIV,
    S_PUSH,
    S_PUSHOP,
    S_FINAL,
    S_EMIT
  } state_t;
endpackage
`default_nettype wire

// File: rtl/iee_front.sv
// Front end: classifies characters into tokens and queues them.
// Depends on iee_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iee_front import iee_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_is_last,
  input  wire logic       in_push,
  output logic            in_full,
  output token_t          tok,
  output logic            tok_valid,
  input  wire logic       tok_take
);
  localparam int AW = $clog2(QUEUE_DEPTH);

  token_t q_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  token_t t;
  logic push_ok, pop_ok;

  always_comb begin
    t.kind  = TK_NONE;
    t.op    = OP_OPEN;
    t.digit = in_char_code[3:0];
    t.last  = in_is_last;
    if (in_char_code >= CH_ZERO && in_char_code <= CH_NINE) t.kind = TK_DIGIT;
    else begin
      case (in_char_code)
        CH_OPEN:  begin t.kind = TK_OPER; t.op = OP_OPEN; end
        CH_CLOSE: t.kind = TK_CLOSE;
        CH_ADD:   begin t.kind = TK_OPER; t.op = OP_ADD; end
        CH_SUB:   begin t.kind = TK_OPER; t.op = OP_SUB; end
        CH_MUL:   begin t.kind = TK_OPER; t.op = OP_MUL; end
        CH_DIV:   begin t.kind = TK_OPER; t.op = OP_DIV; end
        default:  t.kind = TK_NONE;
      endcase
    end
  end

  assign in_full   = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign tok_valid = (cnt_r != '0);
  assign tok       = q_r[rp_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = tok_take && tok_valid;

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= t;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= wp_r + 1'b1;
      if (pop_ok) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
    end
  end
endmodule
`default_nettype wire

// File: rtl/iee_divider.sv
// Restoring divider, one quotient bit per cycle, truncating signed.
// Depends on iee_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iee_divider import iee_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] a,
  input  wire logic [VALUE_WIDTH-1:0] b,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      q
);
  localparam int W = VALUE_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] rem_r, quo_r, den_r;
  logic [CW-1:0] cnt_r;
  logic neg_r, busy_r;
  logic [W:0] trial;

  assign trial = {rem_r, quo_r[W-1]} - {1'b0, den_r};
  assign done  = busy_r && (cnt_r == '0);
  assign q     = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= CW'(W);
      rem_r <= '0;
      quo_r <= a[W-1] ? (~a + 1'b1) : a;
      den_r <= b[W-1] ? (~b + 1'b1) : b;
      neg_r <= a[W-1] ^ b[W-1];
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else begin
        cnt_r <= cnt_r - 1'b1;
        if (!trial[W]) begin
          rem_r <= trial[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[W-2:0], quo_r[W-1]};
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/iee_back.sv
// Back end: operand and operator stacks, reduction sequencer, result register.
// Depends on iee_pkg and iee_divider.
`timescale 1ns / 1ps
`default_nettype none
module iee_back import iee_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  token_t           tok,
  input  wire logic        tok_valid,
  output logic             tok_take,
  output logic [31:0]      out_value,
  output logic [1:0]       out_status,
  output logic             out_empty,
  input  wire logic        out_pop
);
  localparam int W  = VALUE_WIDTH;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [W-1:0] vmem [STACK_DEPTH];
  op_t          omem [STACK_DEPTH];

  state_t st_r, st_nxt;
  logic [CW-1:0] vcnt_r, ocnt_r;
  status_t err_r;
  token_t tk_r;
  logic [W-1:0] a_r, b_r, res_r, vrd_r;
  op_t op_r, ord_r;
  logic [31:0] oval_r;
  logic [1:0] ostat_r;
  logic ovalid_r;

  logic div_start, div_done;
  logic [W-1:0] div_q;
  logic [W-1:0] prod;

  iee_divider #(.VALUE_WIDTH(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .a(a_r), .b(b_r), .done(div_done), .q(div_q)
  );

  assign prod = a_r * b_r;
  assign out_value  = oval_r;
  assign out_status = ostat_r;
  assign out_empty  = !ovalid_r;

  function automatic logic prec_hi(op_t o);
    return (o == OP_MUL) || (o == OP_DIV);
  endfunction

  logic ok;
  logic emit_go;
  logic reduce_here;
  logic final_r;
  assign ok = (err_r == ST_OK);
  assign emit_go = !ovalid_r || out_pop;
  // peek decision: top operator should reduce for current token
  always_comb begin
    reduce_here = 1'b0;
    if (ocnt_r != '0 && ord_r != OP_OPEN) begin
      if (tk_r.kind == TK_CLOSE) reduce_here = 1'b1;
      else if (tk_r.kind == TK_OPER && tk_r.op != OP_OPEN)
        reduce_here = prec_hi(ord_r) || !prec_hi(tk_r.op);
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:   if (tok_valid) begin
        if (tok.kind == TK_DIGIT && err_r == ST_OK) st_nxt = S_DIGIT;
        else if ((tok.kind == TK_OPER || tok.kind == TK_CLOSE) && err_r == ST_OK)
          st_nxt = S_PEEK;
        else if (tok.last) st_nxt = S_FINAL;
      end
      S_DIGIT:  st_nxt = tk_r.last ? S_FINAL : S_IDLE;
      S_PEEK: begin
        if (!ok) st_nxt = tk_r.last ? S_FINAL : S_IDLE;
        else if (reduce_here) st_nxt = S_RED_B;
        else if (tk_r.kind == TK_CLOSE) st_nxt = tk_r.last ? S_FINAL : S_IDLE;
        else st_nxt = S_PUSHOP;
      end
      S_RED_B: begin
        if (vcnt_r < CW'(2)) st_nxt = final_r ? S_FINAL : S_PEEK;
        else st_nxt = S_RED_A;
      end
      S_RED_A:  st_nxt = S_ALU;
      S_ALU:    st_nxt = (op_r == OP_DIV && b_r != '0) ? S_DIV : S_PUSH;
      S_DIV:    if (div_done) st_nxt = S_PUSH;
      S_PUSH:   st_nxt = final_r ? S_FINAL : S_PEEK;
      S_PUSHOP: st_nxt = tk_r.last ? S_FINAL : S_IDLE;
      S_FINAL: begin
        if (!final_r) st_nxt = S_FINAL;
        else if (ok && ocnt_r != '0) begin
          if (ord_r != OP_OPEN) st_nxt = S_RED_B;
        end else st_nxt = S_EMIT;
      end
      S_EMIT:   if (emit_go) st_nxt = S_IDLE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    tok_take  = (st_r == S_IDLE) && tok_valid;
    div_start = (st_r == S_ALU) && (op_r == OP_DIV) && (b_r != '0);
  end

  always_ff @(posedge clk) begin
    vrd_r <= vmem[AW'(vcnt_r - ((st_r == S_RED_B) ? CW'(2) : CW'(1)))];
    ord_r <= omem[AW'(ocnt_r - 1'b1)];
    if (!rst_n) begin
      st_r <= S_IDLE;
      vcnt_r <= '0;
      ocnt_r <= '0;
      err_r <= ST_OK;
      ovalid_r <= 1'b0;
      final_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_EMIT && emit_go) ovalid_r <= 1'b1;
      else if (out_pop && ovalid_r) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (tok_take) begin
          tk_r <= tok;
          final_r <= 1'b0;
        end
        S_DIGIT: begin
          if (vcnt_r == CW'(STACK_DEPTH)) err_r <= ST_OVERFLOW;
          else begin
            vmem[AW'(vcnt_r)] <= W'(tk_r.digit);
            vcnt_r <= vcnt_r + 1'b1;
          end
        end
        S_PEEK: if (ok && !reduce_here && tk_r.kind == TK_CLOSE) begin
          if (ocnt_r == '0) err_r <= ST_MALFORMED;
          else ocnt_r <= ocnt_r - 1'b1;
        end
        S_RED_B: begin
          op_r <= ord_r;
          ocnt_r <= ocnt_r - 1'b1;
          if (vcnt_r < CW'(2)) err_r <= ST_MALFORMED;
          else begin
            b_r <= vrd_r;
            vcnt_r <= vcnt_r - 1'b1;
          end
        end
        S_RED_A: begin
          a_r <= vrd_r;
          vcnt_r <= vcnt_r - 1'b1;
        end
        S_ALU: begin
          case (op_r)
            OP_ADD:  res_r <= a_r + b_r;
            OP_SUB:  res_r <= a_r - b_r;
            OP_MUL:  res_r <= prod;
            default: if (b_r == '0) err_r <= ST_DIVZERO;
          endcase
        end
        S_DIV: if (div_done) res_r <= div_q;
        S_PUSH: if (ok) begin
          vmem[AW'(vcnt_r)] <= res_r;
          vcnt_r <= vcnt_r + 1'b1;
        end
        S_PUSHOP: if (ok) begin
          if (ocnt_r == CW'(STACK_DEPTH)) err_r <= ST_OVERFLOW;
          else begin
            omem[AW'(ocnt_r)] <= tk_r.op;
            ocnt_r <= ocnt_r + 1'b1;
          end
        end
        S_FINAL: begin
          final_r <= 1'b1;
          if (final_r) begin
            if (ok && ocnt_r != '0 && ord_r == OP_OPEN) err_r <= ST_MALFORMED;
            else if (ok && ocnt_r == '0 && vcnt_r != CW'(1)) err_r <= ST_MALFORMED;
          end
        end
        S_EMIT: if (emit_go) begin
          ostat_r <= err_r;
          oval_r <= ok ? 32'(signed'(vrd_r)) : 32'd0;
          vcnt_r <= '0;
          ocnt_r <= '0;
          err_r <= ST_OK;
          final_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/infix_expression_evaluator.sv
// Top level of the infix expression evaluator: front classifier, token queue, back end.
// Depends on iee_pkg, iee_front, iee_back.
//
//  channel | direction | ports                         | beat accepted when
//  input   | in        | in_char_code, in_is_last      | in_push && !in_full
//  result  | out       | out_value, out_status         | out_pop && !out_empty
//
// Each digit, operator and closing parenthesis is handled in turn by the back end; each
// reduction adds its own steps, and a division also waits on the bit-serial divider.
// After the last item the back end settles the drain, does any final reductions, then emits.
// A 4-entry token queue absorbs input bursts. Reset is synchronous; stacks need no
// clearing. A waiting result holds the back end only when the next result is ready.
`timescale 1ns / 1ps
`default_nettype none
module infix_expression_evaluator import iee_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_is_last,
  input  wire logic        in_push,
  output logic             in_full,
  output logic [31:0]      out_value,
  output logic [1:0]       out_status,
  output logic             out_empty,
  input  wire logic        out_pop
);
  token_t tok;
  logic tok_valid, tok_take;

  iee_front u_front (
    .clk(clk), .rst_n(rst_n), .in_char_code(in_char_code), .in_is_last(in_is_last),
    .in_push(in_push), .in_full(in_full), .tok(tok), .tok_valid(tok_valid),
    .tok_take(tok_take)
  );

  iee_back #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .tok(tok), .tok_valid(tok_valid), .tok_take(tok_take),
    .out_value(out_value), .out_status(out_status), .out_empty(out_empty),
    .out_pop(out_pop)
  );
endmodule
`default_nettype wire
